// ===== rtl/lpsst_pkg.sv =====
package lpsst_pkg;

  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int BRANCH_DEF      = 16;

  localparam int CMD_W    = 3;
  localparam int IDXIN_W  = 16;
  localparam int LEN_W    = 20;
  localparam int HM_W     = 16;
  localparam int EXT_W    = 18;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int HIT_W    = 10;
  localparam int TOT_W    = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND     = 3'd0,
    CMD_UPDATE     = 3'd1,
    CMD_FIND_Y     = 3'd2,
    CMD_FIND_BYTE  = 3'd3,
    CMD_FIND_INDEX = 3'd4,
    CMD_CLEAR      = 3'd5,
    CMD_NOP6       = 3'd6,
    CMD_NOP7       = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UPD_RD,
    S_UPD_OLD,
    S_N_RD,
    S_N_EV,
    S_FIX_RD,
    S_FIX_EV,
    S_E_RD,
    S_E_EV,
    S_FIN
  } state_t;

endpackage

// ===== rtl/lpsst_ram.sv =====
module lpsst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/layout_prefix_sum_search_tree_top.sv =====
// Channel  | Handshake              | Payload
// cmd      | cmd_valid / cmd_stall  | command, entry_index, byte_length, height, margin,
//          |                        | target_y, target_byte
// rsp      | rsp_valid / rsp_stall  | status, hit_index, start_byte, start_y, intra_offset,
//          |                        | hit_bytes, hit_extent, entry_total
//
// One command at a time. A search by Y or byte spends a read state and an evaluate state
// on each node and on each entry it walks (one read port per memory, registered read data)
// and then S_FIN, which loads the response; the next command is accepted back in S_IDLE.
// Find by index walks the same way; append adds the node fix-up (S_FIX_RD, S_FIX_EV) and
// update also reads the old entry first (S_UPD_RD, S_UPD_OLD).
// Reset is synchronous and clears only control state; both memories need no clearing.
// A waiting response holds the last step of the next command, not its acceptance.
module layout_prefix_sum_search_tree_top #(
  parameter int MAX_ENTRIES = lpsst_pkg::MAX_ENTRIES_DEF,
  parameter int BRANCH      = lpsst_pkg::BRANCH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cmd_valid,
  output logic                              cmd_stall,
  input  logic [lpsst_pkg::CMD_W-1:0]       command,
  input  logic [lpsst_pkg::IDXIN_W-1:0]     entry_index,
  input  logic [lpsst_pkg::LEN_W-1:0]       byte_length,
  input  logic [lpsst_pkg::HM_W-1:0]        height,
  input  logic [lpsst_pkg::HM_W-1:0]        margin,
  input  logic [lpsst_pkg::WORD_W-1:0]      target_y,
  input  logic [lpsst_pkg::WORD_W-1:0]      target_byte,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic [lpsst_pkg::STATUS_W-1:0]    status,
  output logic [lpsst_pkg::HIT_W-1:0]       hit_index,
  output logic [lpsst_pkg::WORD_W-1:0]      start_byte,
  output logic [lpsst_pkg::WORD_W-1:0]      start_y,
  output logic [lpsst_pkg::WORD_W-1:0]      intra_offset,
  output logic [lpsst_pkg::LEN_W-1:0]       hit_bytes,
  output logic [lpsst_pkg::EXT_W-1:0]       hit_extent,
  output logic [lpsst_pkg::TOT_W-1:0]       entry_total
);

  localparam int LEN_W      = lpsst_pkg::LEN_W;
  localparam int EXT_W      = lpsst_pkg::EXT_W;
  localparam int WORD_W     = lpsst_pkg::WORD_W;
  localparam int IDX_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
  localparam int BASE_W     = $clog2(MAX_ENTRIES + BRANCH + 1);
  localparam int NODE_COUNT = (MAX_ENTRIES + BRANCH - 1) / BRANCH;
  localparam int NODE_AW    = NODE_COUNT > 1 ? $clog2(NODE_COUNT) : 1;
  localparam int NB_W       = LEN_W + $clog2(BRANCH + 1);
  localparam int NY_W       = EXT_W + $clog2(BRANCH + 1);
  localparam int AB_W       = LEN_W + CNT_W;
  localparam int AY_W       = EXT_W + CNT_W;
  localparam int CMP_W      = (AB_W > WORD_W ? AB_W : WORD_W) + 1;
  localparam int IC_W       = CNT_W > lpsst_pkg::IDXIN_W ? CNT_W : lpsst_pkg::IDXIN_W;
  localparam int EW         = LEN_W + EXT_W;
  localparam int NW         = NB_W + NY_W;

  lpsst_pkg::state_t  state, state_next;
  lpsst_pkg::cmd_t    op;
  lpsst_pkg::status_t res_status;

  logic [CNT_W-1:0]   count;
  logic [IDX_W-1:0]   hit;
  logic [IDX_W-1:0]   i;
  logic [NODE_AW-1:0] g;
  logic [BASE_W-1:0]  base;
  logic [AB_W-1:0]    acc_b;
  logic [AY_W-1:0]    acc_y;
  logic               searching;
  logic               by_byte;
  logic               have;
  logic [WORD_W-1:0]  t;
  logic [LEN_W-1:0]   new_len, old_len, res_len;
  logic [EXT_W-1:0]   new_ext, old_ext, res_ext;

  logic               entry_we, node_we;
  logic [IDX_W-1:0]   entry_waddr, entry_raddr;
  logic [EW-1:0]      entry_wdata, entry_rdata;
  logic [NODE_AW-1:0] node_waddr, node_raddr;
  logic [NW-1:0]      node_wdata, node_rdata;

  logic               accept, rsp_free;
  logic               tbl_full, tbl_empty, idx_out;
  logic [EXT_W-1:0]   in_ext;
  logic [BASE_W-1:0]  base_end;
  logic [BASE_W-1:0]  hit_ext, i_next;
  logic [NB_W-1:0]    key_nb;
  logic [NY_W-1:0]    key_ny;
  logic [LEN_W-1:0]   key_el;
  logic [EXT_W-1:0]   key_ee;
  logic [CMP_W-1:0]   sum_sel;
  logic               t_below;
  logic               fresh;
  logic [NB_W-1:0]    fix_b;
  logic [NY_W-1:0]    fix_y;

  lpsst_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (entry_we),
    .waddr (entry_waddr),
    .wdata (entry_wdata),
    .raddr (entry_raddr),
    .rdata (entry_rdata)
  );

  lpsst_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rdata)
  );

  assign accept    = cmd_valid && !cmd_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign tbl_full  = count >= CNT_W'(MAX_ENTRIES);
  assign tbl_empty = count == '0;
  assign idx_out   = IC_W'(entry_index) >= IC_W'(count);
  assign in_ext    = EXT_W'(height) + EXT_W'({margin, 1'b0});
  assign base_end  = base + BASE_W'(BRANCH);
  assign hit_ext   = BASE_W'(hit);
  assign i_next    = BASE_W'(i) + BASE_W'(1);

  assign key_nb = node_rdata[NW-1:NY_W];
  assign key_ny = node_rdata[NY_W-1:0];
  assign key_el = entry_rdata[EW-1:EXT_W];
  assign key_ee = entry_rdata[EXT_W-1:0];

  // One compare serves both levels: running sum plus the key under the read pointer.
  always_comb begin
    if (state == lpsst_pkg::S_N_EV) begin
      sum_sel = by_byte ? CMP_W'(acc_b) + CMP_W'(key_nb) : CMP_W'(acc_y) + CMP_W'(key_ny);
    end else begin
      sum_sel = by_byte ? CMP_W'(acc_b) + CMP_W'(key_el) : CMP_W'(acc_y) + CMP_W'(key_ee);
    end
  end
  assign t_below = CMP_W'(t) < sum_sel;

  // A node that an append opens holds stale sums and is rebuilt from zero.
  assign fresh = (op == lpsst_pkg::CMD_APPEND) && (hit_ext == base);
  assign fix_b = (fresh ? '0 : key_nb) + NB_W'(new_len) - NB_W'(old_len);
  assign fix_y = (fresh ? '0 : key_ny) + NY_W'(new_ext) - NY_W'(old_ext);

  always_comb begin
    state_next = state;
    unique case (state)
      lpsst_pkg::S_IDLE: begin
        if (accept) begin
          case (command)
            lpsst_pkg::CMD_APPEND:
              state_next = tbl_full ? lpsst_pkg::S_FIN : lpsst_pkg::S_N_RD;
            lpsst_pkg::CMD_UPDATE:
              state_next = (tbl_empty || idx_out) ? lpsst_pkg::S_FIN : lpsst_pkg::S_UPD_RD;
            lpsst_pkg::CMD_FIND_INDEX:
              state_next = (tbl_empty || idx_out) ? lpsst_pkg::S_FIN : lpsst_pkg::S_N_RD;
            lpsst_pkg::CMD_FIND_Y, lpsst_pkg::CMD_FIND_BYTE:
              state_next = tbl_empty ? lpsst_pkg::S_FIN : lpsst_pkg::S_N_RD;
            default:
              state_next = lpsst_pkg::S_FIN;
          endcase
        end
      end
      lpsst_pkg::S_UPD_RD:  state_next = lpsst_pkg::S_UPD_OLD;
      lpsst_pkg::S_UPD_OLD: state_next = lpsst_pkg::S_N_RD;
      lpsst_pkg::S_N_RD: begin
        if (!searching && base_end > hit_ext) begin
          state_next = (op == lpsst_pkg::CMD_FIND_INDEX) ? lpsst_pkg::S_E_RD
                                                         : lpsst_pkg::S_FIX_RD;
        end else begin
          state_next = lpsst_pkg::S_N_EV;
        end
      end
      lpsst_pkg::S_N_EV: begin
        if (searching && (base_end >= BASE_W'(count) || t_below)) begin
          state_next = lpsst_pkg::S_E_RD;
        end else begin
          state_next = lpsst_pkg::S_N_RD;
        end
      end
      lpsst_pkg::S_FIX_RD: state_next = lpsst_pkg::S_FIX_EV;
      lpsst_pkg::S_FIX_EV: state_next = lpsst_pkg::S_E_RD;
      lpsst_pkg::S_E_RD:   state_next = lpsst_pkg::S_E_EV;
      lpsst_pkg::S_E_EV: begin
        if (searching) begin
          if (i_next == BASE_W'(count) || i_next == base_end || t_below) begin
            state_next = lpsst_pkg::S_FIN;
          end else begin
            state_next = lpsst_pkg::S_E_RD;
          end
        end else begin
          state_next = (i == hit) ? lpsst_pkg::S_FIN : lpsst_pkg::S_E_RD;
        end
      end
      lpsst_pkg::S_FIN: begin
        if (rsp_free) begin
          state_next = lpsst_pkg::S_IDLE;
        end
      end
      default: state_next = lpsst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall   = state != lpsst_pkg::S_IDLE;
    entry_we    = 1'b0;
    entry_waddr = hit;
    entry_wdata = {new_len, new_ext};
    entry_raddr = i;
    node_we     = 1'b0;
    node_waddr  = g;
    node_wdata  = {fix_b, fix_y};
    node_raddr  = g;
    unique case (state)
      lpsst_pkg::S_IDLE: begin
        if (accept && command == lpsst_pkg::CMD_APPEND && !tbl_full) begin
          entry_we    = 1'b1;
          entry_waddr = IDX_W'(count);
          entry_wdata = {byte_length, in_ext};
        end
      end
      lpsst_pkg::S_UPD_RD:  entry_raddr = hit;
      lpsst_pkg::S_UPD_OLD: entry_we = 1'b1;
      lpsst_pkg::S_FIX_EV:  node_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lpsst_pkg::S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      // In S_FIN the response register is reloaded instead.
      if (rsp_valid && !rsp_stall && state != lpsst_pkg::S_FIN) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        lpsst_pkg::S_IDLE: begin
          if (accept) begin
            op         <= lpsst_pkg::cmd_t'(command);
            new_len    <= byte_length;
            new_ext    <= in_ext;
            old_len    <= '0;
            old_ext    <= '0;
            g          <= '0;
            base       <= '0;
            acc_b      <= '0;
            acc_y      <= '0;
            have       <= 1'b0;
            searching  <= command == lpsst_pkg::CMD_FIND_Y ||
                          command == lpsst_pkg::CMD_FIND_BYTE;
            by_byte    <= command == lpsst_pkg::CMD_FIND_BYTE;
            t          <= (command == lpsst_pkg::CMD_FIND_BYTE) ? target_byte : target_y;
            hit        <= (command == lpsst_pkg::CMD_APPEND) ? IDX_W'(count)
                                                             : IDX_W'(entry_index);
            case (command)
              lpsst_pkg::CMD_APPEND: begin
                res_status <= tbl_full ? lpsst_pkg::ST_FULL : lpsst_pkg::ST_OK;
              end
              lpsst_pkg::CMD_UPDATE, lpsst_pkg::CMD_FIND_INDEX: begin
                res_status <= tbl_empty ? lpsst_pkg::ST_EMPTY :
                              idx_out   ? lpsst_pkg::ST_RANGE : lpsst_pkg::ST_OK;
              end
              lpsst_pkg::CMD_FIND_Y, lpsst_pkg::CMD_FIND_BYTE: begin
                res_status <= tbl_empty ? lpsst_pkg::ST_EMPTY : lpsst_pkg::ST_OK;
              end
              lpsst_pkg::CMD_CLEAR: begin
                res_status <= lpsst_pkg::ST_OK;
                count      <= '0;
              end
              default: res_status <= lpsst_pkg::ST_OK;
            endcase
          end
        end
        lpsst_pkg::S_UPD_OLD: begin
          old_len <= key_el;
          old_ext <= key_ee;
        end
        lpsst_pkg::S_N_RD: begin
          i <= IDX_W'(base);
        end
        lpsst_pkg::S_N_EV: begin
          if (!(searching && (base_end >= BASE_W'(count) || t_below))) begin
            acc_b <= acc_b + AB_W'(key_nb);
            acc_y <= acc_y + AY_W'(key_ny);
            g     <= g + NODE_AW'(1);
            base  <= base_end;
          end
        end
        lpsst_pkg::S_FIX_EV: begin
          if (op == lpsst_pkg::CMD_APPEND) begin
            count <= count + CNT_W'(1);
          end
        end
        lpsst_pkg::S_E_EV: begin
          if (state_next == lpsst_pkg::S_FIN) begin
            have    <= 1'b1;
            hit     <= i;
            res_len <= key_el;
            res_ext <= key_ee;
          end else begin
            acc_b <= acc_b + AB_W'(key_el);
            acc_y <= acc_y + AY_W'(key_ee);
            i     <= i + IDX_W'(1);
          end
        end
        lpsst_pkg::S_FIN: begin
          if (rsp_free) begin
            rsp_valid    <= 1'b1;
            status       <= res_status;
            entry_total  <= lpsst_pkg::TOT_W'(count);
            hit_index    <= have ? lpsst_pkg::HIT_W'(hit) : '0;
            hit_bytes    <= have ? res_len : '0;
            hit_extent   <= have ? res_ext : '0;
            start_byte   <= !have ? '0 :
                            (acc_b > AB_W'(64'hFFFF_FFFF)) ? '1 : WORD_W'(acc_b);
            start_y      <= !have ? '0 :
                            (acc_y > AY_W'(64'hFFFF_FFFF)) ? '1 : WORD_W'(acc_y);
            intra_offset <= (have && by_byte && CMP_W'(t) >= CMP_W'(acc_b)) ?
                            WORD_W'(CMP_W'(t) - CMP_W'(acc_b)) : '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/lpsst_checker.sv =====
module lpsst_checker #(
  parameter int MAX_ENTRIES = lpsst_pkg::MAX_ENTRIES_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           cmd_valid,
  input logic                           cmd_stall,
  input logic                           rsp_valid,
  input logic                           rsp_stall,
  input logic [lpsst_pkg::STATUS_W-1:0] status,
  input logic [lpsst_pkg::HIT_W-1:0]    hit_index,
  input logic [lpsst_pkg::WORD_W-1:0]   start_byte,
  input logic [lpsst_pkg::TOT_W-1:0]    entry_total
);

  localparam int CW = lpsst_pkg::TOT_W + 7;

  // Only one command is worked on at a time.
  a_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command accepted while busy");

  // A stalled response transaction stays in place.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(hit_index) && $stable(start_byte))
    else $error("response changed while stalled");

  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == lpsst_pkg::ST_FULL |-> CW'(entry_total) == CW'(MAX_ENTRIES)
                                                  || MAX_ENTRIES > 2047)
    else $error("full status with table not full");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == lpsst_pkg::ST_EMPTY |-> entry_total == '0)
    else $error("empty status with entries held");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != lpsst_pkg::ST_OK |-> hit_index == '0 && start_byte == '0)
    else $error("failed command returned data");

endmodule

bind layout_prefix_sum_search_tree_top lpsst_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_lpsst_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd_valid),
  .cmd_stall   (cmd_stall),
  .rsp_valid   (rsp_valid),
  .rsp_stall   (rsp_stall),
  .status      (status),
  .hit_index   (hit_index),
  .start_byte  (start_byte),
  .entry_total (entry_total)
);
